[sv/dedeq_pkg.sv]
// Package for the double-ended queue: defaults, operation and status codes, shared types.
package dedeq_pkg;

	// Default sizing
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Operation codes on the command channel (other codes act as a peek)
	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [2:0] MODE_POP_BACK   = 3'd3;
	localparam logic [2:0] MODE_PEEK       = 3'd4;

	// Status codes on the response channel
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_POP_EMPTY = 2'd1;
	localparam logic [1:0] STAT_PUSH_FULL = 2'd2;

	// Command broadcast to every cell of the row
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK
	} cell_op_t;

	// Sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_FORM
	} state_t;

endpackage

[sv/dedeq_ifs.sv]
// Channel interfaces for the double-ended queue: command, response and configuration.
interface dedeq_cmd_if #(
	parameter int DATA_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [2:0]            mode;
	logic [DATA_WIDTH-1:0] push_value;

	modport source (output valid, mode, push_value, input ready);
	modport sink   (input valid, mode, push_value, output ready);
endinterface

interface dedeq_rsp_if #(
	parameter int DATA_WIDTH  = 32,
	parameter int COUNT_WIDTH = 5
);
	logic                   valid;
	logic                   ready;
	logic [DATA_WIDTH-1:0]  popped_value;
	logic [DATA_WIDTH-1:0]  front_value;
	logic [DATA_WIDTH-1:0]  back_value;
	logic [COUNT_WIDTH-1:0] item_count;
	logic [1:0]             status;

	modport source (output valid, popped_value, front_value, back_value, item_count, status,
		input ready);
	modport sink   (input valid, popped_value, front_value, back_value, item_count, status,
		output ready);
endinterface

interface dedeq_cfg_if #(
	parameter int DATA_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] empty_value;

	modport source (output valid, empty_value, input ready);
	modport sink   (input valid, empty_value, output ready);
endinterface

[sv/double_ended_queue_top.sv]
// A command transfer is answered on the response channel via the first-stage result register
// and the output register. The next command is taken only after the response is loaded.
// The cell row updates in the accept cycle; ST_FORM reads front and back from the updated row.
// A waiting response holds the next command in the sequencer until it is taken.
// Reset (arst_n, asynchronous): deque empty, empty value zero.
// Entry data is not reset; only per-cell valid bits are cleared.
module double_ended_queue_top #(
	parameter int DEPTH      = dedeq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = dedeq_pkg::DATA_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	dedeq_cmd_if.sink   cmd,
	dedeq_rsp_if.source rsp,
	dedeq_cfg_if.sink   cfg
);
	import dedeq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      count_q;
	logic [DATA_WIDTH-1:0] empty_q;
	logic [DATA_WIDTH-1:0] popped_s1;
	logic [1:0]            status_s1;
	cell_op_t              op;
	logic [DATA_WIDTH-1:0] popped_d;
	logic [1:0]            status_d;
	logic [CNT_W-1:0]      count_d;
	logic                  cmd_xfer;
	logic                  rsp_load;
	logic                  out_valid_q;
	logic                  full;
	logic                  empty;

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]      cell_valid;
	logic [DEPTH-1:0]      cell_last;
	logic [DATA_WIDTH-1:0] back_sel;

	// Configuration register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= '0;
		end else if (cfg.valid) begin
			empty_q <= cfg.empty_value;
		end
	end

	// Row of cells; cell 0 is the front
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] l_data, r_data;
		logic                  l_valid, r_valid;
		if (i == 0) begin : g_first
			assign l_data  = cmd.push_value;
			assign l_valid = 1'b1;
		end else begin : g_mid
			assign l_data  = cell_data[i-1];
			assign l_valid = cell_valid[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign r_data  = '0;
			assign r_valid = 1'b0;
		end else begin : g_inner
			assign r_data  = cell_data[i+1];
			assign r_valid = cell_valid[i+1];
		end
		dedeq_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.push_value  (cmd.push_value),
			.left_data   (l_data),
			.left_valid  (l_valid),
			.right_data  (r_data),
			.right_valid (r_valid),
			.data_q      (cell_data[i]),
			.valid_q     (cell_valid[i]),
			.last        (cell_last[i])
		);
	end

	// Back entry: exactly one cell flags itself last when the deque holds data
	always_comb begin
		back_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_sel = back_sel | (cell_data[i] & {DATA_WIDTH{cell_last[i]}});
		end
	end

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign cmd_xfer = cmd.valid & cmd.ready;
	assign rsp_load = (state_q == ST_FORM) & (~out_valid_q | rsp.ready);

	// Decode of an accepted command
	always_comb begin
		op       = OP_HOLD;
		popped_d = empty_q;
		status_d = STAT_OK;
		count_d  = count_q;
		if (cmd_xfer) begin
			unique case (cmd.mode)
				MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
					if (full) begin
						status_d = STAT_PUSH_FULL;
					end else begin
						op      = (cmd.mode == MODE_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
						count_d = count_q + CNT_W'(1);
					end
				end
				MODE_POP_FRONT, MODE_POP_BACK: begin
					if (empty) begin
						status_d = STAT_POP_EMPTY;
					end else begin
						op       = (cmd.mode == MODE_POP_FRONT) ? OP_POP_FRONT : OP_POP_BACK;
						popped_d = (cmd.mode == MODE_POP_FRONT) ? cell_data[0] : back_sel;
						count_d  = count_q - CNT_W'(1);
					end
				end
				default: begin
					op = OP_HOLD;
				end
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = ST_FORM;
				end
			end
			ST_FORM: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Count and the first-stage result fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			popped_s1 <= popped_d;
			status_s1 <= status_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp.popped_value <= popped_s1;
			rsp.front_value  <= empty ? empty_q : cell_data[0];
			rsp.back_value   <= empty ? empty_q : back_sel;
			rsp.item_count   <= count_q;
			rsp.status       <= status_s1;
		end
	end

	assign rsp.valid = out_valid_q;

endmodule

[sv/dedeq_cell.sv]
// One cell of the deque row: holds one entry and shifts with its neighbors.
module dedeq_cell #(
	parameter int DATA_WIDTH = dedeq_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dedeq_pkg::cell_op_t   op,
	input  logic [DATA_WIDTH-1:0] push_value,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic                  left_valid,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic                  right_valid,
	output logic [DATA_WIDTH-1:0] data_q,
	output logic                  valid_q,
	output logic                  last
);
	import dedeq_pkg::*;

	// This cell holds the back entry
	assign last = valid_q & ~right_valid;

	// Occupancy: shifts toward the back on a front push, toward the front on a front pop; back ops extend or trim it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (op)
				OP_PUSH_FRONT: valid_q <= left_valid;
				OP_PUSH_BACK:  valid_q <= valid_q | left_valid;
				OP_POP_FRONT:  valid_q <= right_valid;
				OP_POP_BACK:   valid_q <= valid_q & right_valid;
				default:       valid_q <= valid_q;
			endcase
		end
	end

	// Entry data, no reset
	always_ff @(posedge clk) begin
		unique case (op)
			OP_PUSH_FRONT: data_q <= left_data;
			OP_PUSH_BACK: begin
				if (!valid_q && left_valid) begin
					data_q <= push_value;
				end
			end
			OP_POP_FRONT:  data_q <= right_data;
			default:       data_q <= data_q;
		endcase
	end

endmodule

[sv/dedeq_checker.sv]
// Port-level checker for the double-ended queue, bound to the top level.
module dedeq_checker #(
	parameter int DEPTH       = dedeq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH  = dedeq_pkg::DATA_WIDTH_DEF,
	parameter int COUNT_WIDTH = $clog2(DEPTH + 1)
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cmd_valid,
	input logic                   cmd_ready,
	input logic                   rsp_valid,
	input logic [DATA_WIDTH-1:0]  popped_value,
	input logic [DATA_WIDTH-1:0]  front_value,
	input logic [DATA_WIDTH-1:0]  back_value,
	input logic [COUNT_WIDTH-1:0] item_count,
	input logic [1:0]             status
);
	import dedeq_pkg::*;

	// Count never exceeds the row length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> item_count <= COUNT_WIDTH'(DEPTH))
		else $error("item_count above depth");

	// A refused push only happens on a full deque
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STAT_PUSH_FULL |-> item_count == COUNT_WIDTH'(DEPTH))
		else $error("push refused while not full");

	// A pop on empty leaves nothing and reports the empty value everywhere
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STAT_POP_EMPTY |->
			item_count == '0 && popped_value == front_value && front_value == back_value)
		else $error("pop on empty reported inconsistent fields");

	// A single entry is both front and back
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && item_count == COUNT_WIDTH'(1) |-> front_value == back_value)
		else $error("front and back differ with one entry");

	// One command in flight: no transfer in the cycle after a transfer
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted on consecutive cycles");

endmodule

bind double_ended_queue_top dedeq_checker #(
	.DEPTH      (DEPTH),
	.DATA_WIDTH (DATA_WIDTH),
	.COUNT_WIDTH(CNT_W)
) u_dedeq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.rsp_valid    (rsp.valid),
	.popped_value (rsp.popped_value),
	.front_value  (rsp.front_value),
	.back_value   (rsp.back_value),
	.item_count   (rsp.item_count),
	.status       (rsp.status)
);
